/* design/pvoa_pkg.sv */
// ----------------------------------------------------------------------------
// pvoa_pkg : shared types for the polyphonic voice allocator
// Scan packet, table write command, result record and controller states.
// ----------------------------------------------------------------------------
package pvoa_pkg;

  // Slot index width inside the cell chain, wide enough for the largest voice count.
  localparam int IDX_W   = 6;
  localparam int KEY_W   = 7;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 3;

  typedef enum logic {
    OP_NOTE_ON  = 1'b0,
    OP_NOTE_OFF = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Search state carried from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    note;
    logic                idle_found;
    logic [IDX_W-1:0]    free_idx;
    logic                old_valid;
    logic [IDX_W-1:0]    old_idx;
    logic [STAMP_W-1:0]  old_stamp;
    logic [KEY_W-1:0]    old_key;
    logic                rel_found;
    logic [IDX_W-1:0]    rel_idx;
    logic [STAMP_W-1:0]  rel_stamp;
  } scan_t;

  // Broadcast write to the slot table.
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic                gate;
    logic                load;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    strength;
    logic [STAMP_W-1:0]  stamp;
  } wr_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic                slot_found;
    logic                gate_level;
    logic                voice_stolen;
    logic [KEY_W-1:0]    stolen_note;
  } res_t;

endpackage

/* design/pvoa_if.sv */
// ----------------------------------------------------------------------------
// pvoa_if : valid/ready channels of the voice allocator
// Event channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface pvoa_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [6:0] note;
  logic [6:0] velocity;

  modport source (output valid, output operation, output note, output velocity, input ready);
  modport sink   (input valid, input operation, input note, input velocity, output ready);
endinterface

interface pvoa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot_index;
  logic       slot_found;
  logic       gate_level;
  logic       voice_stolen;
  logic [6:0] stolen_note;

  modport source (output valid, output slot_index, output slot_found, output gate_level,
                  output voice_stolen, output stolen_note, input ready);
  modport sink   (input valid, input slot_index, input slot_found, input gate_level,
                  input voice_stolen, input stolen_note, output ready);
endinterface

/* design/polyphonic_voice_allocator_top.sv */
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top : voice allocation with oldest-note stealing
// Row of slot cells scanned by a travelling packet, then at most one broadcast write.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  carries note events (operation, note, velocity); a transaction
//            completes when valid and ready are both high at a clock edge.
//   out_chan returns one result per event: the slot assigned or released,
//            whether one was found, the new gate and any stolen note.
//   One event is in flight at a time. A search packet is registered on
//   acceptance, enters the first cell and steps one cell per cycle down
//   the chain. When it leaves the last cell the table write and result
//   capture follow, and the result moves into the output register once
//   that is free. A new event is taken only after the previous result has
//   entered the output register.
//   Reset (rst_n low, synchronous) clears every slot to inactive with zero
//   note and stamp, and zeroes the event counter.
//   When the receiver stalls the result holds in the output register while
//   the next event is accepted and scanned; that event waits for the output
//   register to free before it completes.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_top #(
  parameter int VOICES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  pvoa_in_if.sink           in_chan,
  pvoa_out_if.source        out_chan
);

  pvoa_pkg::state_t                 state_r, state_nxt;
  logic                             op_r;
  logic [pvoa_pkg::KEY_W-1:0]       note_r;
  logic [pvoa_pkg::KEY_W-1:0]       vel_r;
  logic [pvoa_pkg::STAMP_W-1:0]     cnt_r;
  pvoa_pkg::scan_t                  launch_r, launch_nxt;
  pvoa_pkg::scan_t                  chain [VOICES];
  pvoa_pkg::scan_t                  tail;
  pvoa_pkg::wr_t                    wr;
  pvoa_pkg::res_t                   res_r, res_nxt, out_r;
  logic                             out_valid_r;
  logic                             accept;
  logic                             commit;
  logic                             push;
  logic                             out_free;
  logic                             commit_on;
  logic [VOICES:0]                  vld;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign tail     = chain[VOICES-1];

  // Cell chain: each cell takes the packet of its neighbour below.
  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    pvoa_cell #(.CELL_IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_in  ((g == 0) ? launch_r : chain[(g == 0) ? 0 : g-1]),
      .scan_out (chain[g]),
      .wr       (wr)
    );
    assign vld[g+1] = chain[g].valid;
  end
  assign vld[0] = launch_r.valid;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pvoa_pkg::S_IDLE: if (accept)     state_nxt = pvoa_pkg::S_SCAN;
      pvoa_pkg::S_SCAN: if (tail.valid) state_nxt = pvoa_pkg::S_DONE;
      pvoa_pkg::S_DONE: if (out_free)   state_nxt = pvoa_pkg::S_IDLE;
      default:                          state_nxt = pvoa_pkg::S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_chan.ready = 1'b0;
    commit        = 1'b0;
    push          = 1'b0;
    unique case (state_r)
      pvoa_pkg::S_IDLE: in_chan.ready = 1'b1;
      pvoa_pkg::S_SCAN: commit        = tail.valid;
      pvoa_pkg::S_DONE: push          = out_free;
      default: ;
    endcase
  end

  assign commit_on = commit && (op_r == pvoa_pkg::OP_NOTE_ON);

  // Build a fresh search packet for the event being accepted.
  always_comb begin
    launch_nxt = '0;
    if (accept) begin
      launch_nxt.valid = 1'b1;
      launch_nxt.note  = in_chan.note;
    end
  end

  // Decide from the packet leaving the last cell and build the table write.
  always_comb begin
    wr       = '0;
    res_nxt  = '0;
    wr.key      = note_r;
    wr.strength = vel_r;
    wr.stamp    = cnt_r + 32'd1;
    if (commit) begin
      if (op_r == pvoa_pkg::OP_NOTE_ON) begin
        wr.en   = 1'b1;
        wr.load = 1'b1;
        wr.gate = 1'b1;
        wr.idx  = tail.idle_found ? tail.free_idx : tail.old_idx;
        res_nxt.slot_index   = wr.idx[pvoa_pkg::SLOT_W-1:0];
        res_nxt.slot_found   = 1'b1;
        res_nxt.gate_level   = 1'b1;
        res_nxt.voice_stolen = !tail.idle_found;
        res_nxt.stolen_note  = tail.idle_found ? '0 : tail.old_key;
      end else if (tail.rel_found) begin
        // release: drop the gate, keep the slot contents
        wr.en  = 1'b1;
        wr.idx = tail.rel_idx;
        res_nxt.slot_index = tail.rel_idx[pvoa_pkg::SLOT_W-1:0];
        res_nxt.slot_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvoa_pkg::S_IDLE;
      cnt_r       <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      // launch a fresh search packet on acceptance
      launch_r <= launch_nxt;
      if (commit_on) begin
        cnt_r <= cnt_r + 32'd1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.operation;
      note_r <= in_chan.note;
      vel_r  <= in_chan.velocity;
    end
    if (commit) begin
      res_r <= res_nxt;
    end
    if (push) begin
      out_r <= res_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.slot_index   = out_r.slot_index;
  assign out_chan.slot_found   = out_r.slot_found;
  assign out_chan.gate_level   = out_r.gate_level;
  assign out_chan.voice_stolen = out_r.voice_stolen;
  assign out_chan.stolen_note  = out_r.stolen_note;

  // Only one search packet may travel the chain.
  a_one_packet : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld))
    else $error("more than one scan packet in the cell chain");

  // The packet leaves the chain only while the controller waits for it.
  a_tail_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == pvoa_pkg::S_SCAN))
    else $error("scan packet left the chain outside the scan state");

  // The event counter advances by one on each note-on commit.
  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    commit_on |=> (cnt_r == $past(cnt_r) + 32'd1))
    else $error("event counter did not advance on note on");

  // A result without a slot carries neither gate nor steal.
  a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.slot_found) |->
      (!out_chan.gate_level && !out_chan.voice_stolen && (out_chan.stolen_note == 7'd0)))
    else $error("empty result carries slot data");

endmodule

/* design/pvoa_cell.sv */
// ----------------------------------------------------------------------------
// pvoa_cell : one voice slot of the allocator chain
// Holds one slot and folds it into the passing scan packet, registered on its way to the next cell.
// ----------------------------------------------------------------------------
module pvoa_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pvoa_pkg::scan_t scan_in,
  output pvoa_pkg::scan_t scan_out,
  input  pvoa_pkg::wr_t   wr
);

  localparam logic [pvoa_pkg::IDX_W-1:0] MY_IDX = CELL_IDX[pvoa_pkg::IDX_W-1:0];

  logic [pvoa_pkg::KEY_W-1:0]   key_r;
  logic [pvoa_pkg::KEY_W-1:0]   strength_r;
  logic [pvoa_pkg::STAMP_W-1:0] stamp_r;
  logic                         on_r;
  pvoa_pkg::scan_t              scan_r;
  pvoa_pkg::scan_t              scan_nxt;

  always_comb begin
    scan_nxt = scan_in;
    // first inactive slot wins
    if (!on_r && !scan_in.idle_found) begin
      scan_nxt.idle_found = 1'b1;
      scan_nxt.free_idx   = MY_IDX;
    end
    // strictly smaller stamp: lowest slot wins ties
    if (!scan_in.old_valid || (stamp_r < scan_in.old_stamp)) begin
      scan_nxt.old_valid = 1'b1;
      scan_nxt.old_idx   = MY_IDX;
      scan_nxt.old_stamp = stamp_r;
      scan_nxt.old_key   = key_r;
    end
    // greater or equal stamp: highest slot wins ties
    if (on_r && (key_r == scan_in.note) && (stamp_r >= scan_in.rel_stamp)) begin
      scan_nxt.rel_found = 1'b1;
      scan_nxt.rel_idx   = MY_IDX;
      scan_nxt.rel_stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      strength_r <= '0;
      stamp_r    <= '0;
      on_r       <= 1'b0;
      scan_r     <= '0;
    end else begin
      scan_r <= scan_in.valid ? scan_nxt : '0;
      if (wr.en && (wr.idx == MY_IDX)) begin
        on_r <= wr.gate;
        if (wr.load) begin
          key_r      <= wr.key;
          strength_r <= wr.strength;
          stamp_r    <= wr.stamp;
        end
      end
    end
  end

  assign scan_out = scan_r;

endmodule

/* verif/pvoa_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvoa_result_checker : slot table predictor and result comparison
// Watches both channels, keeps its own copy of the voice table, works out
// the slot report for every accepted event and checks each returned result
// against the oldest report still due.
// ----------------------------------------------------------------------------
module pvoa_result_checker #(
  parameter int VOICES = 8
) (
  input  logic clk,
  input  logic rst_n,
  pvoa_in_if   in_mon,
  pvoa_out_if  out_mon,
  output int   fault_count,
  output int   awaited_results
);
  import pvoa_pkg::*;

  logic [KEY_W-1:0]   key_tbl      [VOICES];
  logic [KEY_W-1:0]   strength_tbl [VOICES];
  logic [STAMP_W-1:0] stamp_tbl    [VOICES];
  logic               gate_tbl     [VOICES];
  logic [STAMP_W-1:0] note_on_count;

  res_t slot_reports_due[$];

  // Apply one event to the shadow table and return the slot report it causes.
  function automatic res_t allocate_voice(op_t op, logic [KEY_W-1:0] note,
                                          logic [KEY_W-1:0] vel);
    res_t               rep;
    int                 idle_slot;
    int                 oldest_slot;
    int                 victim;
    logic [STAMP_W-1:0] oldest_stamp;
    logic [STAMP_W-1:0] newest_stamp;
    rep = '0;
    if (op == OP_NOTE_ON) begin
      idle_slot    = VOICES;
      oldest_slot  = 0;
      oldest_stamp = '1;
      for (int i = 0; i < VOICES; i++) begin
        if (!gate_tbl[i] && idle_slot == VOICES) idle_slot = i;
        if (stamp_tbl[i] < oldest_stamp) begin
          oldest_stamp = stamp_tbl[i];
          oldest_slot  = i;
        end
      end
      victim = (idle_slot < VOICES) ? idle_slot : oldest_slot;
      if (idle_slot == VOICES) begin
        rep.voice_stolen = 1'b1;
        rep.stolen_note  = key_tbl[victim];
      end
      note_on_count          = note_on_count + 32'd1;
      key_tbl[victim]        = note;
      strength_tbl[victim]   = vel;
      stamp_tbl[victim]      = note_on_count;
      gate_tbl[victim]       = 1'b1;
      rep.slot_index         = victim[SLOT_W-1:0];
      rep.slot_found         = 1'b1;
      rep.gate_level         = 1'b1;
    end else begin
      // Latest holder of the key wins; ties go to the higher slot.
      victim       = VOICES;
      newest_stamp = '0;
      for (int i = 0; i < VOICES; i++) begin
        if (gate_tbl[i] && key_tbl[i] == note && stamp_tbl[i] >= newest_stamp) begin
          newest_stamp = stamp_tbl[i];
          victim       = i;
        end
      end
      if (victim < VOICES) begin
        gate_tbl[victim] = 1'b0;
        rep.slot_index   = victim[SLOT_W-1:0];
        rep.slot_found   = 1'b1;
      end
    end
    return rep;
  endfunction

  always @(posedge clk) begin
    res_t due;
    res_t seen;
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        key_tbl[i]      = '0;
        strength_tbl[i] = '0;
        stamp_tbl[i]    = '0;
        gate_tbl[i]     = 1'b0;
      end
      note_on_count = '0;
      slot_reports_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.slot_index   = out_mon.slot_index;
        seen.slot_found   = out_mon.slot_found;
        seen.gate_level   = out_mon.gate_level;
        seen.voice_stolen = out_mon.voice_stolen;
        seen.stolen_note  = out_mon.stolen_note;
        if (slot_reports_due.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with nothing due: slot %0d found %0b gate %0b stolen %0b/%0d",
                     $realtime, seen.slot_index, seen.slot_found, seen.gate_level,
                     seen.voice_stolen, seen.stolen_note);
        end else begin
          due = slot_reports_due.pop_front();
          if (seen.slot_index   !== due.slot_index   ||
              seen.slot_found   !== due.slot_found   ||
              seen.gate_level   !== due.gate_level   ||
              seen.voice_stolen !== due.voice_stolen ||
              seen.stolen_note  !== due.stolen_note) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"%0t: mismatch: expected slot %0d found %0b gate %0b stolen %0b/%0d,",
                        " got slot %0d found %0b gate %0b stolen %0b/%0d"},
                       $realtime, due.slot_index, due.slot_found, due.gate_level,
                       due.voice_stolen, due.stolen_note, seen.slot_index,
                       seen.slot_found, seen.gate_level, seen.voice_stolen,
                       seen.stolen_note);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        slot_reports_due.push_back(allocate_voice(op_t'(in_mon.operation), in_mon.note,
                                                  in_mon.velocity));
    end
    awaited_results = slot_reports_due.size();
  end

endmodule

/* verif/polyphonic_voice_allocator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top_tb : voice allocator testbench
// Drives note events in random bursts against a randomly stalling receiver.
// A directed opening covers key extremes, releases with and without a match,
// duplicate keys and stealing; random phases over small key pools follow.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_top_tb;
  import pvoa_pkg::*;

  localparam int VOICES       = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE       = VOICES + 8;

  // Receiver behaviours, picked per window.
  localparam int RX_OPEN   = 0;
  localparam int RX_JITTER = 1;
  localparam int RX_LONG   = 2;

  logic clk;
  logic rst_n;
  int   fault_count;
  int   awaited_results;

  pvoa_in_if  in_chan ();
  pvoa_out_if out_chan ();

  polyphonic_voice_allocator_top #(.VOICES(VOICES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pvoa_result_checker #(.VOICES(VOICES)) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .fault_count     (fault_count),
    .awaited_results (awaited_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: each window picks always-ready, random jitter or long stalls,
  // so back-pressure lands on every phase of the scan.
  int rx_mode   = RX_OPEN;
  int mode_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= $urandom_range(RX_OPEN, RX_LONG);
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        out_chan.ready <= 1'b1;
      end
      RX_JITTER: begin
        out_chan.ready <= ($urandom_range(0, 2) != 0);
      end
      default: begin
        if (hold_left != 0) begin
          hold_left      <= hold_left - 1;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
          hold_left      <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : 0;
        end
      end
    endcase
  end

  // Present one event and hold it until the transaction completes; valid
  // stays high on return so a burst can carry straight on.
  task automatic post_event(op_t op, logic [6:0] note, logic [6:0] vel);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.note      <= note;
    in_chan.velocity  <= vel;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drop valid and hold off until every result due has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (awaited_results != 0);
    @(posedge clk);
  endtask

  logic [6:0] key_pool[8];
  int         on_bias;
  int         burst_left;
  logic [6:0] pick_note;
  op_t        pick_op;

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.operation <= OP_NOTE_ON;
    in_chan.note      <= '0;
    in_chan.velocity  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Key extremes, release of a held key, release with no match and
    // release of a key that only an inactive slot still holds.
    post_event(OP_NOTE_ON,  7'd0,   7'd0);
    post_event(OP_NOTE_ON,  7'd127, 7'd127);
    post_event(OP_NOTE_OFF, 7'd127, 7'd0);
    post_event(OP_NOTE_OFF, 7'd127, 7'd0);
    post_event(OP_NOTE_OFF, 7'd0,   7'd127);
    post_event(OP_NOTE_OFF, 7'd0,   7'd0);
    // Fill every slot, key 60 held twice.
    post_event(OP_NOTE_ON,  7'd60,  7'd100);
    post_event(OP_NOTE_ON,  7'd60,  7'd1);
    for (int k = 61; k <= 66; k++) post_event(OP_NOTE_ON, 7'(k), 7'(k));
    // Duplicate key: the newer holder goes first, then the older.
    post_event(OP_NOTE_OFF, 7'd60,  7'd0);
    post_event(OP_NOTE_OFF, 7'd60,  7'd0);
    post_event(OP_NOTE_ON,  7'd60,  7'd64);
    post_event(OP_NOTE_ON,  7'd60,  7'd85);
    // Table full: steal the oldest voice, release the thief, steal again.
    post_event(OP_NOTE_ON,  7'd85,  7'd42);
    post_event(OP_NOTE_OFF, 7'd85,  7'd0);
    post_event(OP_NOTE_OFF, 7'd42,  7'd0);
    post_event(OP_NOTE_ON,  7'd42,  7'd127);
    post_event(OP_NOTE_ON,  7'd127, 7'd85);
    drain_results();

    // Random phases: each draws a small key pool so releases usually match,
    // and a note-on bias that swings between filling and emptying the table.
    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        foreach (key_pool[j]) key_pool[j] = 7'($urandom_range(0, 127));
        on_bias = $urandom_range(30, 75);
      end
      if (n % 130 == 129) drain_results();
      if ($urandom_range(0, 7) == 0)
        pick_note = 7'($urandom_range(0, 127));
      else
        pick_note = key_pool[$urandom_range(0, 7)];
      pick_op = ($urandom_range(1, 100) <= on_bias) ? OP_NOTE_ON : OP_NOTE_OFF;
      post_event(pick_op, pick_note, 7'($urandom_range(0, 127)));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          in_chan.valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end

    // Wait for the tail, then give the block time to show any stray result.
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0 && awaited_results == 0)
      $display("polyphonic_voice_allocator_top_tb passed");
    else
      $display("polyphonic_voice_allocator_top_tb failed");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("polyphonic_voice_allocator_top_tb failed");
    $finish;
  end

endmodule
